// ----- src/irpft_pkg.sv -----
// Package for the infrared printer frame transmitter.
// Holds frame timing constants, register indexes and the parity encoder.
// No dependencies.
`default_nettype none

package irpft_pkg;

	// Queue depth default, one slot always left free
	localparam int unsigned FIFO_DEPTH = 32;

	// Word layout: data byte in bits 7:0, four parity bits in 11:8
	localparam int unsigned WORD_W = 12;

	// Parity masks for word bits 8, 9, 10 and 11
	localparam logic [7:0] PAR_MASK0 = 8'b1000_1011;
	localparam logic [7:0] PAR_MASK1 = 8'b1101_0101;
	localparam logic [7:0] PAR_MASK2 = 8'b1110_0110;
	localparam logic [7:0] PAR_MASK3 = 8'b0111_1000;

	// Frame timing, in carrier ticks
	localparam logic [5:0] BIT_WAIT   = 6'd27;
	localparam logic [5:0] START_WAIT = 6'd13;
	localparam logic [5:0] GAP_WAIT   = 6'd41;
	localparam logic [2:0] BURST_LEN  = 3'd7;
	localparam logic [3:0] ZERO_DELAY = 4'd13;
	localparam logic [3:0] FRAME_BITS = 4'd15;
	localparam logic [3:0] DATA_BITS_TOP = 4'd11;

	// Line pacing
	localparam logic [7:0]  CRED_MAX   = 8'd4;
	localparam logic [7:0]  CRED_FAST  = 8'd128;
	localparam logic [7:0]  LINE_END_A = 8'h04;
	localparam logic [7:0]  LINE_END_B = 8'h0A;
	localparam logic [16:0] PERIOD_RST = 17'd65536;

	// Register map, indexed by paddr[3:2]
	typedef enum logic [1:0] {
		REG_SLOW_MODE   = 2'd0,
		REG_LINE_PERIOD = 2'd1,
		REG_TX_INVERT   = 2'd2
	} reg_idx_t;

	// Build the 12-bit word: byte plus masked parities
	function automatic logic [WORD_W-1:0] encode_word(input logic [7:0] b);
		logic [3:0] par;
		par[0] = ^(b & PAR_MASK0);
		par[1] = ^(b & PAR_MASK1);
		par[2] = ^(b & PAR_MASK2);
		par[3] = ^(b & PAR_MASK3);
		return {par, b};
	endfunction

endpackage

`default_nettype wire

// ----- src/irpft_word_ram.sv -----
// Word queue storage for the infrared frame transmitter.
// One write port, one read port with registered read data; uses no package.
`default_nettype none

module irpft_word_ram #(
	parameter int unsigned DEPTH  = 32,
	parameter int unsigned ADDR_W = 5,
	parameter int unsigned DATA_W = 12
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write on request, read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- src/ir_printer_frame_transmitter_unit.sv -----
// Infrared printer frame transmitter: one item (tick or byte write) per cycle while the result buffer has room.
// Each result is registered in the result buffer before it drives the output port.
// The queue head word is read ahead from a RAM with registered read data, with write forwarding.
// A two-entry result buffer lets input keep flowing while one result waits.
// Reset clears pointers and frame timers and sets credits to CRED_MAX; queue RAM contents stay undefined.
`default_nettype none

module ir_printer_frame_transmitter_unit #(
	parameter int unsigned FIFO_DEPTH = irpft_pkg::FIFO_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// item input
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        cmd,
	input  wire logic [7:0]  data_byte,
	// result output
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             ir_drive,
	output logic             accepted,
	output logic             fifo_empty,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int unsigned AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned WW = irpft_pkg::WORD_W;
	localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);

	typedef struct packed {
		logic ir_drive;
		logic accepted;
		logic fifo_empty;
	} res_t;

	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + AW'(1);
	endfunction

	// configuration registers
	logic        slow_q;
	logic [16:0] period_q;
	logic        invert_q;

	// frame and queue state
	logic [AW-1:0] head_q, tail_q;
	logic [WW-1:0] frame_q;
	logic [3:0]    bits_q;
	logic [5:0]    wait_q;
	logic [3:0]    bdelay_q;
	logic          bpend_q;
	logic [2:0]    pulses_q;
	logic [7:0]    cred_q;
	logic [16:0]   timer_q;

	// result buffer
	logic v0_q, v1_q;
	res_t r0_q, r1_q;

	// head word read path
	logic [WW-1:0] ram_rdata;
	logic          fwd_q;
	logic [WW-1:0] fwd_word_q;
	logic [WW-1:0] head_word;

	// next-state values
	logic [AW-1:0] head_v, tail_v, raddr;
	logic [WW-1:0] frame_v, wword;
	logic [3:0]    bits_v;
	logic [5:0]    wait_v;
	logic [3:0]    bdelay_v;
	logic          bpend_v;
	logic [2:0]    pulses_v;
	logic [7:0]    cred_v;
	logic [16:0]   timer_v;
	logic          drive_v, acc_v, we;
	res_t          res_v;

	logic in_fire, out_fire, cfg_wr;

	assign in_fire  = in_valid & in_ready;
	assign out_fire = out_valid & out_ready;
	assign in_ready = ~v1_q;
	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_q   <= 1'b0;
			period_q <= irpft_pkg::PERIOD_RST;
			invert_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				irpft_pkg::REG_SLOW_MODE:   slow_q   <= pwdata[0];
				irpft_pkg::REG_LINE_PERIOD: period_q <= pwdata[16:0];
				irpft_pkg::REG_TX_INVERT:   invert_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Configuration read-back
	always_comb begin
		unique case (paddr[3:2])
			irpft_pkg::REG_SLOW_MODE:   prdata = {31'd0, slow_q};
			irpft_pkg::REG_LINE_PERIOD: prdata = {15'd0, period_q};
			irpft_pkg::REG_TX_INVERT:   prdata = {31'd0, invert_q};
			default:                    prdata = 32'd0;
		endcase
	end

	// Head word: forwarded write data when the read raced a write to the same entry
	assign head_word = fwd_q ? fwd_word_q : ram_rdata;

	// Process one item
	always_comb begin
		cred_v   = cred_q;
		timer_v  = timer_q;
		head_v   = head_q;
		tail_v   = tail_q;
		frame_v  = frame_q;
		bits_v   = bits_q;
		wait_v   = wait_q;
		bdelay_v = bdelay_q;
		bpend_v  = bpend_q;
		pulses_v = pulses_q;
		drive_v  = 1'b0;
		acc_v    = 1'b0;
		we       = 1'b0;
		wword    = irpft_pkg::encode_word(data_byte);

		// cap credits in slow mode, park them in fast mode
		if (slow_q) begin
			if (cred_v > irpft_pkg::CRED_MAX) begin
				cred_v = irpft_pkg::CRED_MAX;
			end
		end else begin
			cred_v  = irpft_pkg::CRED_FAST;
			timer_v = '0;
		end

		if (cmd) begin
			// queue a non-zero byte unless the ring is full
			if (data_byte == 8'd0) begin
				acc_v = 1'b1;
			end else if (next_idx(tail_q) != head_q) begin
				we     = 1'b1;
				tail_v = next_idx(tail_q);
				acc_v  = 1'b1;
			end
		end else begin
			// line credit accrual
			if (slow_q) begin
				timer_v = timer_v + 17'd1;
				if (timer_v >= period_q) begin
					timer_v = '0;
					if (cred_v < irpft_pkg::CRED_MAX) begin
						cred_v = cred_v + 8'd1;
					end
				end
			end
			// carrier burst
			if (pulses_v != 3'd0) begin
				drive_v  = 1'b1;
				pulses_v = pulses_v - 3'd1;
			end
			// bit timing
			if (wait_v == 6'd0) begin
				wait_v = irpft_pkg::BIT_WAIT;
				if (bits_v == 4'd0) begin
					if (!(slow_q && cred_v == 8'd0) && head_q != tail_q) begin
						frame_v = head_word;
						if ((frame_v[7:0] == irpft_pkg::LINE_END_A ||
						     frame_v[7:0] == irpft_pkg::LINE_END_B) && cred_v != 8'd0) begin
							cred_v = cred_v - 8'd1;
						end
						head_v = next_idx(head_q);
						bits_v = irpft_pkg::FRAME_BITS;
					end
				end else begin
					bits_v = bits_v - 4'd1;
					if (bits_v > irpft_pkg::DATA_BITS_TOP) begin
						wait_v   = irpft_pkg::START_WAIT;
						pulses_v = irpft_pkg::BURST_LEN;
					end else if (frame_v[bits_v]) begin
						pulses_v = irpft_pkg::BURST_LEN;
					end else begin
						bpend_v  = 1'b1;
						bdelay_v = irpft_pkg::ZERO_DELAY;
					end
					if (bits_v == 4'd0) begin
						wait_v = irpft_pkg::GAP_WAIT;
					end
				end
			end else begin
				wait_v = wait_v - 6'd1;
			end
			// delayed burst for a zero bit
			if (bpend_v) begin
				if (bdelay_v == 4'd0) begin
					bpend_v  = 1'b0;
					pulses_v = irpft_pkg::BURST_LEN;
				end else begin
					bdelay_v = bdelay_v - 4'd1;
				end
			end
		end

		res_v.ir_drive   = drive_v ^ invert_q;
		res_v.accepted   = acc_v;
		res_v.fifo_empty = (head_v == tail_v);
	end

	// Read ahead at the head the next item will see
	assign raddr = in_fire ? head_v : head_q;

	irpft_word_ram #(
		.DEPTH (FIFO_DEPTH),
		.ADDR_W(AW),
		.DATA_W(WW)
	) u_ram (
		.clk  (clk),
		.we   (we & in_fire),
		.waddr(tail_q),
		.wdata(wword),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// Forward a write that lands on the entry being read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= we & in_fire & (tail_q == raddr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_word_q <= wword;
	end

	// Commit item state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			frame_q  <= '0;
			bits_q   <= '0;
			wait_q   <= '0;
			bdelay_q <= '0;
			bpend_q  <= 1'b0;
			pulses_q <= '0;
			cred_q   <= irpft_pkg::CRED_MAX;
			timer_q  <= '0;
		end else if (in_fire) begin
			head_q   <= head_v;
			tail_q   <= tail_v;
			frame_q  <= frame_v;
			bits_q   <= bits_v;
			wait_q   <= wait_v;
			bdelay_q <= bdelay_v;
			bpend_q  <= bpend_v;
			pulses_q <= pulses_v;
			cred_q   <= cred_v;
			timer_q  <= timer_v;
		end
	end

	// Result buffer: slot 0 drives the port, slot 1 catches a stalled transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			if (out_fire) begin
				v0_q <= v1_q | in_fire;
				v1_q <= v1_q & in_fire;
			end else if (in_fire) begin
				v0_q <= 1'b1;
				v1_q <= v0_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire) begin
			r0_q <= v1_q ? r1_q : res_v;
			r1_q <= res_v;
		end else if (in_fire) begin
			if (v0_q) begin
				r1_q <= res_v;
			end else begin
				r0_q <= res_v;
			end
		end
	end

	assign out_valid  = v0_q;
	assign ir_drive   = r0_q.ir_drive;
	assign accepted   = r0_q.accepted;
	assign fifo_empty = r0_q.fifo_empty;

`ifndef SYNTHESIS
	// The spare slot is only ever filled behind a waiting result
	a_slot_order: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q |-> v0_q)
		else $error("result spare slot holds data while front slot is empty");

	// A result only leaves by a transfer
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped without transfer");

	// The ring never fills its last slot
	a_ring_room: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && we) |-> (next_idx(tail_q) != head_q))
		else $error("write into a full word ring");

	// Bit timer stays within the frame gap
	a_wait_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wait_q <= irpft_pkg::GAP_WAIT) && (bdelay_q <= irpft_pkg::ZERO_DELAY))
		else $error("frame timer out of range");
`endif

endmodule

`default_nettype wire
